### hdl/hlbs_pkg.sv
// hit lamp and buzzer sequencer package: command, phase and register codes,
// the sequencer state struct and the count load helper
// no dependencies
package hlbs_pkg;

    localparam int COUNT_BITS = 24;
    localparam int CFG_W      = 24;
    localparam int CMD_W      = 3;
    localparam int IMG_W      = 7;
    localparam int PH_W       = 2;

    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_HIT     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_EXPIRED = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SELF    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_BREAK   = 3'd4;

    localparam logic [PH_W-1:0] PH_IDLE      = 2'd0;
    localparam logic [PH_W-1:0] PH_HIT_BUZZ  = 2'd1;
    localparam logic [PH_W-1:0] PH_HIT_LAMPS = 2'd2;
    localparam logic [PH_W-1:0] PH_EXP_BUZZ  = 2'd3;

    localparam logic REG_BUZZER_TICKS = 1'b0;
    localparam logic REG_LIGHT_TICKS  = 1'b1;

    localparam logic [CFG_W-1:0] BUZZER_TICKS_RST = 24'd1000000;
    localparam logic [CFG_W-1:0] LIGHT_TICKS_RST  = 24'd2000000;

    localparam int BIT_BUZZ   = 0;
    localparam int BIT_SELF_B = 1;
    localparam int BIT_ON_B   = 2;
    localparam int BIT_OFF_B  = 3;
    localparam int BIT_SELF_A = 4;
    localparam int BIT_ON_A   = 5;
    localparam int BIT_OFF_A  = 6;

    typedef struct packed {
        logic [IMG_W-1:0]      image;
        logic [PH_W-1:0]       phase;
        logic [COUNT_BITS-1:0] countdown;
        logic                  hit;
        logic                  expiry;
        logic                  stop;
    } seq_state_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             on_target_a;
        logic             off_target_a;
        logic             on_target_b;
        logic             off_target_b;
        logic             self_contact_a;
        logic             self_contact_b;
        logic             break_a;
        logic             break_b;
    } seq_cmd_t;

    function automatic logic [COUNT_BITS-1:0] count_load(input logic [CFG_W-1:0] v);
        logic [CFG_W+COUNT_BITS-1:0] wide;
        wide = {{COUNT_BITS{1'b0}}, v};
        return wide[COUNT_BITS-1:0];
    endfunction

endpackage

### hdl/hlbs_next.sv
// next-state logic of the hit lamp and buzzer sequencer for one command beat
// depends on hlbs_pkg
module hlbs_next (
    input  hlbs_pkg::seq_state_t          cur,
    input  hlbs_pkg::seq_cmd_t            cmd,
    input  logic [hlbs_pkg::CFG_W-1:0]    buzzer_ticks,
    input  logic [hlbs_pkg::CFG_W-1:0]    light_ticks,
    output hlbs_pkg::seq_state_t          nxt
);

    logic hit_any;
    logic hit_bad;

    assign hit_any = cmd.on_target_a | cmd.off_target_a | cmd.on_target_b | cmd.off_target_b;
    assign hit_bad = (cmd.on_target_a & cmd.off_target_a) | (cmd.on_target_b & cmd.off_target_b);

    always_comb begin
        nxt = cur;
        unique case (cmd.command)
            hlbs_pkg::CMD_TICK: begin
                if (cur.phase != hlbs_pkg::PH_IDLE) begin
                    if (cur.countdown <= hlbs_pkg::COUNT_BITS'(1)) begin
                        unique case (cur.phase)
                            hlbs_pkg::PH_HIT_BUZZ: begin
                                nxt.image[hlbs_pkg::BIT_BUZZ] = 1'b0;
                                nxt.phase     = hlbs_pkg::PH_HIT_LAMPS;
                                nxt.countdown = hlbs_pkg::count_load(light_ticks);
                            end
                            hlbs_pkg::PH_HIT_LAMPS: begin
                                nxt.image[hlbs_pkg::BIT_ON_A]  = 1'b0;
                                nxt.image[hlbs_pkg::BIT_OFF_A] = 1'b0;
                                nxt.image[hlbs_pkg::BIT_ON_B]  = 1'b0;
                                nxt.image[hlbs_pkg::BIT_OFF_B] = 1'b0;
                                nxt.stop      = 1'b0;
                                nxt.hit       = 1'b0;
                                nxt.phase     = hlbs_pkg::PH_IDLE;
                                nxt.countdown = '0;
                            end
                            default: begin
                                nxt.image[hlbs_pkg::BIT_BUZZ] = 1'b0;
                                nxt.expiry    = 1'b0;
                                nxt.phase     = hlbs_pkg::PH_IDLE;
                                nxt.countdown = '0;
                            end
                        endcase
                    end else begin
                        nxt.countdown = cur.countdown - hlbs_pkg::COUNT_BITS'(1);
                    end
                end
            end
            hlbs_pkg::CMD_HIT: begin
                if (hit_any && !hit_bad) begin
                    nxt.image[hlbs_pkg::BIT_ON_A]  = cmd.on_target_a;
                    nxt.image[hlbs_pkg::BIT_OFF_A] = cmd.off_target_a;
                    nxt.image[hlbs_pkg::BIT_ON_B]  = cmd.on_target_b;
                    nxt.image[hlbs_pkg::BIT_OFF_B] = cmd.off_target_b;
                    nxt.image[hlbs_pkg::BIT_BUZZ]  = 1'b1;
                    nxt.stop      = 1'b1;
                    nxt.hit       = 1'b1;
                    nxt.expiry    = 1'b0;
                    nxt.phase     = hlbs_pkg::PH_HIT_BUZZ;
                    nxt.countdown = hlbs_pkg::count_load(buzzer_ticks);
                end
            end
            hlbs_pkg::CMD_EXPIRED: begin
                if (!cur.hit && !cur.expiry) begin
                    nxt.expiry    = 1'b1;
                    nxt.image[hlbs_pkg::BIT_BUZZ] = 1'b1;
                    nxt.phase     = hlbs_pkg::PH_EXP_BUZZ;
                    nxt.countdown = hlbs_pkg::count_load(buzzer_ticks);
                end
            end
            hlbs_pkg::CMD_SELF: begin
                nxt.image[hlbs_pkg::BIT_SELF_A] = cmd.self_contact_a;
                nxt.image[hlbs_pkg::BIT_SELF_B] = cmd.self_contact_b;
            end
            hlbs_pkg::CMD_BREAK: begin
                nxt.image[hlbs_pkg::BIT_OFF_A] = cmd.break_a;
                nxt.image[hlbs_pkg::BIT_OFF_B] = cmd.break_b;
            end
            default: begin
                nxt = cur;
            end
        endcase
    end

endmodule

### hdl/hit_light_buzzer_sequencer_top.sv
// hit lamp and buzzer sequencer top: config registers, state and result register
// depends on hlbs_pkg and hlbs_next
// a beat accepted at one edge shows its result on m_* after that edge
// throughput 1 beat per cycle; one result register parts the channels and s_ready
// falls only while that register is full and m_ready is low
// reset: sync active-low aresetn clears state and m_valid, ticks to 1000000/2000000
module hit_light_buzzer_sequencer_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [hlbs_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [hlbs_pkg::CMD_W-1:0]    s_command,
    input  logic                          s_on_target_a,
    input  logic                          s_off_target_a,
    input  logic                          s_on_target_b,
    input  logic                          s_off_target_b,
    input  logic                          s_self_contact_a,
    input  logic                          s_self_contact_b,
    input  logic                          s_break_a,
    input  logic                          s_break_b,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [hlbs_pkg::IMG_W-1:0]    m_lamp_image,
    output logic                          m_stop_line,
    output logic                          m_hit_showing,
    output logic                          m_expiry_sounding
);

    logic [hlbs_pkg::CFG_W-1:0] buzzer_ticks_reg;
    logic [hlbs_pkg::CFG_W-1:0] light_ticks_reg;
    hlbs_pkg::seq_state_t       state_reg;
    hlbs_pkg::seq_state_t       state_next;
    hlbs_pkg::seq_cmd_t         cmd;
    logic                       m_valid_reg;
    logic [hlbs_pkg::IMG_W-1:0] lamp_image_reg;
    logic                       stop_line_reg;
    logic                       hit_showing_reg;
    logic                       expiry_sounding_reg;
    logic                       s_accept;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    assign cmd.command        = s_command;
    assign cmd.on_target_a    = s_on_target_a;
    assign cmd.off_target_a   = s_off_target_a;
    assign cmd.on_target_b    = s_on_target_b;
    assign cmd.off_target_b   = s_off_target_b;
    assign cmd.self_contact_a = s_self_contact_a;
    assign cmd.self_contact_b = s_self_contact_b;
    assign cmd.break_a        = s_break_a;
    assign cmd.break_b        = s_break_b;

    hlbs_next u_next (
        .cur          (state_reg),
        .cmd          (cmd),
        .buzzer_ticks (buzzer_ticks_reg),
        .light_ticks  (light_ticks_reg),
        .nxt          (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buzzer_ticks_reg <= hlbs_pkg::BUZZER_TICKS_RST;
            light_ticks_reg  <= hlbs_pkg::LIGHT_TICKS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                hlbs_pkg::REG_BUZZER_TICKS: buzzer_ticks_reg <= cfg_data;
                hlbs_pkg::REG_LIGHT_TICKS:  light_ticks_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.image     <= '0;
            state_reg.phase     <= hlbs_pkg::PH_IDLE;
            state_reg.countdown <= '0;
            state_reg.hit       <= 1'b0;
            state_reg.expiry    <= 1'b0;
            state_reg.stop      <= 1'b0;
            m_valid_reg         <= 1'b0;
        end else begin
            if (s_accept) begin
                state_reg <= state_next;
            end
            if (s_accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result beat payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            lamp_image_reg      <= state_next.image;
            stop_line_reg       <= state_next.stop;
            hit_showing_reg     <= state_next.hit;
            expiry_sounding_reg <= state_next.expiry;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_lamp_image      = lamp_image_reg;
    assign m_stop_line       = stop_line_reg;
    assign m_hit_showing     = hit_showing_reg;
    assign m_expiry_sounding = expiry_sounding_reg;

    a_hit_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.hit == ((state_reg.phase == hlbs_pkg::PH_HIT_BUZZ) ||
                          (state_reg.phase == hlbs_pkg::PH_HIT_LAMPS)))
        else $error("hit flag out of step with phase");

    a_stop_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.stop == state_reg.hit)
        else $error("stop line out of step with hit sequence");

    a_buzz_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.image[hlbs_pkg::BIT_BUZZ] ==
            ((state_reg.phase == hlbs_pkg::PH_HIT_BUZZ) ||
             (state_reg.phase == hlbs_pkg::PH_EXP_BUZZ)))
        else $error("buzzer bit out of step with phase");

    a_idle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase == hlbs_pkg::PH_IDLE) |-> (state_reg.countdown == '0))
        else $error("countdown running while idle");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("accepted beat gave no result");

endmodule
